FILE: hw/rtl/tsr_pkg.sv
// shared types and constants for the tile scanline renderer
package tsr_pkg;

    localparam logic [1:0] KIND_VRAM   = 2'd0;
    localparam logic [1:0] KIND_OAM    = 2'd1;
    localparam logic [1:0] KIND_RENDER = 2'd2;

    localparam logic [2:0] REG_LCDC = 3'd0;
    localparam logic [2:0] REG_SCY  = 3'd1;
    localparam logic [2:0] REG_SCX  = 3'd2;
    localparam logic [2:0] REG_WY   = 3'd3;
    localparam logic [2:0] REG_WX   = 3'd4;
    localparam logic [2:0] REG_BGP  = 3'd5;
    localparam logic [2:0] REG_OBP0 = 3'd6;
    localparam logic [2:0] REG_OBP1 = 3'd7;

    localparam logic [12:0] MAP_LO = 13'h1800;
    localparam logic [12:0] MAP_HI = 13'h1C00;

    function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] ci);
        return pal[2*ci +: 2];
    endfunction

endpackage

FILE: hw/rtl/tile_scanline_renderer_unit.sv
// tile scanline renderer: memories, line buffers and the line sequencer
// Usage: input channel (i_valid/o_ready) carries one item: kind 0 writes a
// byte of video memory, kind 1 writes a byte of object memory, kind 2
// renders line i_line_number. Registers are written over i_cfg_we/
// i_cfg_index/i_cfg_data; the user must do so only while idle, as the
// block itself does not enforce it. Writes give no result. A render walks
// the line pixel by pixel through one video memory read port; with objects
// on, it then reads each object from object memory and draws those on the
// line. Then (LINE_WIDTH+7)/8 results stream out one per cycle while the
// receiver does not stall.
// Results leave through an output register. When the receiver stalls, the
// sequencer waits on each group. Once the last group is in the output
// register the block is ready again, so a new item may be taken while that
// last result still waits.
// Reset (synchronous, active low) clears control state and registers;
// the memories hold undefined data until written.
module tile_scanline_renderer_unit #(
    parameter int LINE_WIDTH   = 160,
    parameter int LINE_COUNT   = 144,
    parameter int OBJECT_COUNT = 40,
    parameter int VIDEO_BYTES  = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [12:0] i_mem_address,
    input  logic [7:0]  i_write_byte,
    input  logic [7:0]  i_line_number,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pixel_group,
    output logic [4:0]  o_group_index,
    output logic        o_last_group,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import tsr_pkg::*;

    localparam int OBJ_BYTES = OBJECT_COUNT * 4;
    localparam int OAW  = $clog2(OBJ_BYTES);
    localparam int VAW  = $clog2(VIDEO_BYTES);
    localparam int GROUPS = (LINE_WIDTH + 7) / 8;
    localparam int XW   = $clog2(LINE_WIDTH);
    localparam int NW   = $clog2(OBJECT_COUNT + 1);
    localparam int GW   = $clog2(GROUPS + 1);
    localparam int GXW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_BMAP  = 14'b00000000000010,
        S_BLO   = 14'b00000000000100,
        S_BHI   = 14'b00000000001000,
        S_BPIX  = 14'b00000000010000,
        S_OY    = 14'b00000000100000,
        S_OX    = 14'b00000001000000,
        S_OT    = 14'b00000010000000,
        S_OA    = 14'b00000100000000,
        S_OLO   = 14'b00001000000000,
        S_OHI   = 14'b00010000000000,
        S_OPIX  = 14'b00100000000000,
        S_EMIT  = 14'b01000000000000,
        S_WR    = 14'b10000000000000
    } t_state;

    t_state r_state;

    logic [7:0] r_lcdc, r_scy, r_scx, r_wy, r_wx, r_bgp, r_obp0, r_obp1;

    logic [7:0] r_vram [VIDEO_BYTES];
    logic [7:0] r_oam  [OBJ_BYTES];
    // one word per run of eight pixels, pixel k in bits 2k+1..2k
    logic [15:0] r_bgi [GROUPS];
    logic [15:0] r_shd [GROUPS];

    logic [VAW-1:0] v_addr;
    logic [7:0]     r_vdata;
    logic [OAW-1:0] o_addr;
    logic [7:0]     r_odata;

    logic [1:0]  r_kind;
    logic [12:0] r_addr;
    logic [7:0]  r_byte, r_line;
    logic [XW-1:0] r_x;
    logic          r_win;
    logic [7:0]  r_mx, r_my, r_lo;
    logic [NW-1:0] r_n;
    logic [7:0]  r_oy, r_ox, r_ot, r_oa, r_ohi;
    logic [3:0]  r_k;
    logic [GW-1:0] r_g;
    logic        r_ovalid;
    logic [15:0] r_pg;
    logic [4:0]  r_gi;
    logic        r_last;

    // window and pixel geometry
    logic signed [9:0] wy_s, wx_s, oy_s;
    logic        win_line, win_here;
    logic [3:0]  height;
    logic        on_line;
    logic [3:0]  orow;
    logic [7:0]  otile;
    logic signed [9:0] px_s;
    logic [XW-1:0]  px_u;
    logic [GXW-1:0] xg, pxg;
    logic [1:0]  px_bgi;
    logic [2:0]  col;
    logic [1:0]  oci, bci;
    logic [2:0]  bsh;
    logic [7:0]  bmx;
    logic [12:0] tile_base, map_base;

    assign wy_s     = $signed({2'b00, r_line}) - $signed({2'b00, r_wy});
    assign win_line = r_lcdc[5] && (wy_s >= 0) && (wy_s < LINE_COUNT);
    assign wx_s     = $signed({{(10-XW){1'b0}}, r_x}) + 10'sd7 - $signed({2'b00, r_wx});
    assign win_here = win_line && (wx_s >= 0);
    assign height   = r_lcdc[2] ? 4'd15 : 4'd7;
    assign oy_s     = $signed({2'b00, r_oy}) - 10'sd16;
    assign on_line  = !(oy_s > $signed({2'b00, r_line}))
                      && ($signed({2'b00, r_line}) - oy_s <= $signed({6'd0, height}));
    logic [3:0] raw_row;
    assign raw_row  = 4'(r_line - (r_oy - 8'd16));
    assign orow     = r_oa[6] ? (height - raw_row) : raw_row;
    assign otile    = r_lcdc[2] ? {r_ot[7:1], 1'b0} : r_ot;
    assign px_s     = $signed({2'b00, r_ox}) - 10'sd8 + $signed({7'd0, r_k[2:0]});
    assign px_u     = XW'(px_s);
    assign xg       = GXW'(r_x >> 3);
    assign pxg      = GXW'(px_u >> 3);
    assign px_bgi   = r_bgi[pxg][2*px_u[2:0] +: 2];
    assign col      = r_oa[5] ? 3'(7 - r_k[2:0]) : r_k[2:0];
    assign oci      = {r_ohi[3'(7 - col)], r_lo[3'(7 - col)]};
    assign bsh      = 3'(7 - r_mx[2:0]);
    assign bci      = {r_vdata[bsh], r_lo[bsh]};
    assign bmx      = 8'(r_x) + r_scx;
    assign map_base = (r_win ? r_lcdc[6] : r_lcdc[3]) ? MAP_HI : MAP_LO;
    assign tile_base = r_lcdc[4] ? {1'b0, r_vdata, 4'd0}
                                 : 13'({1'b0, r_vdata ^ 8'h80, 4'd0} + 13'h0800);

    // one address to video memory per cycle
    logic [12:0] map_a;
    always_comb begin
        map_a = map_base + {3'd0, r_my[7:3], r_mx[7:3]};
        unique case (r_state)
            S_BMAP:  v_addr = VAW'(map_a);
            S_BLO:   v_addr = VAW'(tile_base + {8'd0, r_my[2:0], 1'b0});
            S_BHI:   v_addr = VAW'(r_addr + 13'd1);
            S_OLO:   v_addr = VAW'({1'b0, otile, 4'd0} + {8'd0, orow, 1'b0});
            S_OHI:   v_addr = VAW'(r_addr + 13'd1);
            default: v_addr = VAW'(r_addr);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR && r_kind == KIND_VRAM) begin
            r_vram[VAW'(r_addr)] <= r_byte;
        end
        r_vdata <= r_vram[v_addr];
    end

    assign o_addr = OAW'({r_n, 2'b00}) + OAW'(
        (r_state == S_OY) ? 2'd0 : (r_state == S_OX) ? 2'd1 :
        (r_state == S_OT) ? 2'd2 : 2'd3);
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR && r_kind == KIND_OAM && r_addr < 13'(OBJ_BYTES)) begin
            r_oam[OAW'(r_addr)] <= r_byte;
        end
        r_odata <= r_oam[o_addr];
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc <= '0; r_scy <= '0; r_scx <= '0; r_wy <= '0;
            r_wx <= '0; r_bgp <= '0; r_obp0 <= '0; r_obp1 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LCDC: r_lcdc <= i_cfg_data;
                REG_SCY:  r_scy  <= i_cfg_data;
                REG_SCX:  r_scx  <= i_cfg_data;
                REG_WY:   r_wy   <= i_cfg_data;
                REG_WX:   r_wx   <= i_cfg_data;
                REG_BGP:  r_bgp  <= i_cfg_data;
                REG_OBP0: r_obp0 <= i_cfg_data;
                REG_OBP1: r_obp1 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: one memory read in flight, states advance after read data lands
    logic [1:0] r_wait;
    logic [15:0] grp;
    always_comb begin
        grp = r_shd[GXW'(r_g)];
        // pixels past the line end read as shade 0
        for (int k = 0; k < 8; k++) begin
            if (int'(r_g) * 8 + k >= LINE_WIDTH)
                grp[2*k +: 2] = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_wait   <= '0;
        end else begin
            if (r_ovalid && i_ready && r_state != S_EMIT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind <= i_kind; r_addr <= i_mem_address;
                        r_byte <= i_write_byte; r_line <= i_line_number;
                        r_x <= '0; r_n <= NW'(OBJECT_COUNT - 1); r_g <= '0;
                        r_wait <= '0;
                        if (i_kind == KIND_RENDER) r_state <= S_BMAP;
                        else                       r_state <= S_WR;
                    end
                end
                S_WR: r_state <= S_IDLE;
                S_BMAP: begin
                    // choose window or background coordinates for this pixel, or clear it when bg is off
                    if (r_wait == 2'd0) begin
                        if (!r_lcdc[0]) begin
                            r_bgi[xg][2*r_x[2:0] +: 2] <= 2'd0;
                            r_shd[xg][2*r_x[2:0] +: 2] <= 2'd0;
                            r_state <= S_BPIX;
                        end else begin
                            r_win <= win_here;
                            r_mx  <= win_here ? 8'(wx_s) : bmx;
                            r_my  <= win_here ? 8'(wy_s) : (r_line + r_scy);
                            r_wait <= 2'd1;
                        end
                    end else if (r_wait == 2'd1) begin
                        r_wait <= 2'd2;
                    end else begin
                        r_wait <= 2'd0;
                        r_state <= S_BLO;
                    end
                end
                S_BLO: begin
                    r_addr <= 13'(v_addr);
                    r_state <= S_BHI;
                    r_wait <= 2'd0;
                end
                S_BHI: begin
                    if (r_wait == 2'd0) begin
                        r_lo <= r_vdata; r_wait <= 2'd1;
                    end else begin
                        r_wait <= 2'd0;
                        r_bgi[xg][2*r_x[2:0] +: 2] <= bci;
                        r_shd[xg][2*r_x[2:0] +: 2] <= shade_of(r_bgp, bci);
                        r_state <= S_BPIX;
                    end
                end
                S_BPIX: begin
                    if (r_x == XW'(LINE_WIDTH - 1)) begin
                        r_state <= r_lcdc[1] ? S_OY : S_EMIT;
                    end else begin
                        r_x <= r_x + 1'b1;
                        r_state <= S_BMAP;
                    end
                end
                S_OY: begin
                    if (r_wait == 2'd1) begin r_oy <= r_odata; r_wait <= '0; r_state <= S_OX; end
                    else r_wait <= r_wait + 1'b1;
                end
                S_OX: begin
                    if (r_wait == 2'd1) begin r_ox <= r_odata; r_wait <= '0; r_state <= S_OT; end
                    else r_wait <= r_wait + 1'b1;
                end
                S_OT: begin
                    if (r_wait == 2'd1) begin r_ot <= r_odata; r_wait <= '0; r_state <= S_OA; end
                    else r_wait <= r_wait + 1'b1;
                end
                S_OA: begin
                    if (r_wait == 2'd1) begin
                        r_oa <= r_odata; r_wait <= '0; r_state <= S_OLO;
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_OLO: begin
                    if (!on_line) begin
                        if (r_n == '0) r_state <= S_EMIT;
                        else begin r_n <= r_n - 1'b1; r_state <= S_OY; end
                    end else begin
                        r_addr <= 13'(v_addr);
                        r_state <= S_OHI; r_wait <= '0;
                    end
                end
                S_OHI: begin
                    if (r_wait == 2'd0) begin
                        r_lo <= r_vdata; r_wait <= 2'd1;
                    end else begin
                        r_ohi <= r_vdata;
                        r_wait <= 2'd0; r_k <= '0; r_state <= S_OPIX;
                    end
                end
                S_OPIX: begin
                    // r_ohi holds the high plane byte through these steps
                    if (px_s >= 0 && px_s < LINE_WIDTH && oci != 2'd0 &&
                        !(r_oa[7] && px_bgi != 2'd0)) begin
                        r_shd[pxg][2*px_u[2:0] +: 2] <= shade_of(r_oa[4] ? r_obp1 : r_obp0, oci);
                    end
                    if (r_k == 4'd7) begin
                        if (r_n == '0) r_state <= S_EMIT;
                        else begin r_n <= r_n - 1'b1; r_state <= S_OY; end
                    end
                    r_k <= r_k + 1'b1;
                end
                S_EMIT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_pg   <= grp;
                        r_gi   <= 5'(r_g);
                        r_last <= (r_g == GW'(GROUPS - 1));
                        if (r_g == GW'(GROUPS - 1)) r_state <= S_IDLE;
                        else r_g <= r_g + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_pixel_group = r_pg;
    assign o_group_index = r_gi;
    assign o_last_group  = r_last;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pixel_group)))
        else $error("result dropped");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_g == GW'(GROUPS - 1) && (!r_ovalid || i_ready))
        |=> (r_state == S_IDLE)) else $error("no return to idle");
`endif

endmodule
